// ===== src/bbd_pkg.sv =====
`default_nettype none
package bbd_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 4096;
    localparam int LINES_KEPT  = 4;
    localparam int LINE_SEL_W  = $clog2(LINES_KEPT);
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int PIX_W       = 8;
    localparam int COL_W       = 11;
    localparam int ROW_W       = 12;
    localparam int FW_W        = 12;
    localparam int FH_W        = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_BORDER   = 2'd1;
    localparam logic [1:0] KIND_INTERIOR = 2'd2;

    typedef struct packed {
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
    } rgb_t;

    typedef struct packed {
        rgb_t [3:0]       px;
        logic [COL_W-1:0] x;
        logic [ROW_W-1:0] y;
    } quad_t;

endpackage
`default_nettype wire

// ===== src/bbd_ram.sv =====
`default_nettype none
module bbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== src/bbd_front.sv =====
`default_nettype none
module bbd_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    input  wire logic [bbd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bbd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            accept,
    input  wire logic [bbd_pkg::PIX_W-1:0]       raw_pixel,
    output logic                                 push,
    output bbd_pkg::quad_t                       quad,
    output logic [1:0]                           pending
);
    import bbd_pkg::*;

    logic [FW_W-1:0]  frame_width_reg;
    logic [FH_W-1:0]  frame_height_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [FW_W-1:0]  fw_even, w_eff;
    logic [FH_W-1:0]  fh_even, h_eff;
    logic             in_range;
    logic [FW_W-1:0]  col_inc;
    logic [FH_W-1:0]  row_inc;
    logic [1:0]       kind;
    logic [COL_W-1:0] qx;
    logic [ROW_W-1:0] qy;

    logic                  s1_valid_reg;
    logic [1:0]            s1_kind_reg;
    logic [PIX_W-1:0]      s1_pixel_reg;
    logic [LINE_SEL_W-1:0] s1_line_reg;
    logic [COL_W-1:0]      s1_x_reg;
    logic [ROW_W-1:0]      s1_y_reg;
    logic                  s2_valid_reg;
    logic [1:0]            s2_kind_reg;
    logic [COL_W-1:0]      s2_x_reg;
    logic [ROW_W-1:0]      s2_y_reg;

    logic [PIX_W-1:0] rdata [LINES_KEPT];
    logic [PIX_W-1:0] column [4];
    logic [PIX_W-1:0] win_reg [4][4];

    function automatic logic [PIX_W-1:0] avg2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        logic [PIX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[PIX_W:1];
    endfunction

    function automatic logic [PIX_W-1:0] avg4(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c,
                                              input logic [PIX_W-1:0] d);
        logic [PIX_W+1:0] s;
        s = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
        return s[PIX_W+1:2];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_FRAME_WIDTH)
            begin
                frame_width_reg <= cfg_data[FW_W-1:0];
            end
            else if (cfg_index == REG_FRAME_HEIGHT)
            begin
                frame_height_reg <= cfg_data;
            end
        end
    end

    // Effective frame size: even, clamped to the supported range.
    always_comb
    begin
        fw_even = {frame_width_reg[FW_W-1:1], 1'b0};
        fh_even = {frame_height_reg[FH_W-1:1], 1'b0};
        if (fw_even > FW_W'(MAX_WIDTH))
            w_eff = FW_W'(MAX_WIDTH);
        else if (fw_even < FW_W'(2))
            w_eff = FW_W'(2);
        else
            w_eff = fw_even;
        if (fh_even > FH_W'(MAX_HEIGHT))
            h_eff = FH_W'(MAX_HEIGHT);
        else if (fh_even < FH_W'(2))
            h_eff = FH_W'(2);
        else
            h_eff = fh_even;
    end

    always_comb
    begin
        in_range = ({1'b0, col_reg} < w_eff) && ({1'b0, row_reg} < h_eff);
        col_inc  = {1'b0, col_reg} + FW_W'(1);
        row_inc  = {1'b0, row_reg} + FH_W'(1);
        if (col_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            row_next = row_reg;
        end

        kind = KIND_NONE;
        qx   = col_reg - COL_W'(1);
        qy   = row_reg - ROW_W'(1);
        if (in_range && col_reg[0] && row_reg[0])
        begin
            if (col_reg == COL_W'(1) || row_reg == ROW_W'(1)
                || {1'b0, col_reg} == w_eff - FW_W'(1)
                || {1'b0, row_reg} == h_eff - FH_W'(1))
            begin
                kind = KIND_BORDER;
            end
        end
        else if (in_range && !col_reg[0] && !row_reg[0]
                 && col_reg >= COL_W'(4) && row_reg >= ROW_W'(4)
                 && ({1'b0, col_reg} + FW_W'(2)) <= w_eff
                 && ({1'b0, row_reg} + FH_W'(2)) <= h_eff)
        begin
            kind = KIND_INTERIOR;
            qx   = col_reg - COL_W'(2);
            qy   = row_reg - ROW_W'(2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_kind_reg  <= KIND_NONE;
            s2_valid_reg <= 1'b0;
            s2_kind_reg  <= KIND_NONE;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s2_kind_reg  <= s1_kind_reg;
            if (accept)
            begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                s1_kind_reg <= kind;
            end
            else
            begin
                s1_kind_reg <= KIND_NONE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= raw_pixel;
            s1_line_reg  <= row_reg[LINE_SEL_W-1:0];
            s1_x_reg     <= qx;
            s1_y_reg     <= qy;
        end
        s2_x_reg <= s1_x_reg;
        s2_y_reg <= s1_y_reg;
    end

    // One bank per line, indexed by row modulo the number of lines kept.
    for (genvar i = 0; i < LINES_KEPT; i++)
    begin : g_bank
        bbd_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_bank (
            .clk   (clk),
            .we    (accept && in_range && row_reg[LINE_SEL_W-1:0] == LINE_SEL_W'(i)),
            .waddr (col_reg[ADDR_W-1:0]),
            .wdata (raw_pixel),
            .raddr (col_reg[ADDR_W-1:0]),
            .rdata (rdata[i])
        );
    end

    // Column of the four newest rows: index 3 is the current row.
    always_comb
    begin
        column[3] = s1_pixel_reg;
        for (int i = 0; i < 3; i++)
        begin
            column[i] = rdata[s1_line_reg - LINE_SEL_W'(3 - i)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            for (int j = 0; j < 3; j++)
            begin
                win_reg[j] <= win_reg[j + 1];
            end
            for (int i = 0; i < 4; i++)
            begin
                win_reg[3][i] <= column[i];
            end
        end
    end

    // The window holds columns c-3..c and rows r-3..r of the item in stage two.
    always_comb
    begin
        quad.x = s2_x_reg;
        quad.y = s2_y_reg;
        if (s2_kind_reg == KIND_BORDER)
        begin
            for (int k = 0; k < 4; k++)
            begin
                quad.px[k].r = win_reg[2][3];
                quad.px[k].b = win_reg[3][2];
                quad.px[k].g = avg2(win_reg[2][2], win_reg[3][3]);
            end
            quad.px[0].g = win_reg[2][2];
            quad.px[3].g = win_reg[3][3];
        end
        else
        begin
            quad.px[0].r = avg2(win_reg[1][2], win_reg[1][0]);
            quad.px[0].g = win_reg[1][1];
            quad.px[0].b = avg2(win_reg[0][1], win_reg[2][1]);
            quad.px[1].r = avg4(win_reg[1][2], win_reg[3][2], win_reg[1][0], win_reg[3][0]);
            quad.px[1].g = avg4(win_reg[1][1], win_reg[3][1], win_reg[2][0], win_reg[2][2]);
            quad.px[1].b = win_reg[2][1];
            quad.px[2].r = win_reg[1][2];
            quad.px[2].g = avg4(win_reg[1][1], win_reg[1][3], win_reg[0][2], win_reg[2][2]);
            quad.px[2].b = avg4(win_reg[2][1], win_reg[0][1], win_reg[2][3], win_reg[0][3]);
            quad.px[3].r = avg2(win_reg[1][2], win_reg[3][2]);
            quad.px[3].g = win_reg[2][2];
            quad.px[3].b = avg2(win_reg[2][1], win_reg[2][3]);
        end
    end

    assign push    = s2_valid_reg && (s2_kind_reg != KIND_NONE);
    assign pending = {1'b0, s1_kind_reg != KIND_NONE} + {1'b0, push};
endmodule
`default_nettype wire

// ===== src/bbd_quad_fifo.sv =====
`default_nettype none
module bbd_quad_fifo (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    input  wire bbd_pkg::quad_t            push_quad,
    input  wire logic                      pop,
    output bbd_pkg::quad_t                 head,
    output logic                           not_empty,
    output logic [bbd_pkg::QCNT_W-1:0]     count
);
    import bbd_pkg::*;

    quad_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [QCNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_quad;
        end
    end

    assign head      = entry_reg[rptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;
endmodule
`default_nettype wire

// ===== src/bbd_back.sv =====
`default_nettype none
module bbd_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire bbd_pkg::quad_t              head,
    input  wire logic                        not_empty,
    output logic                             pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [bbd_pkg::PIX_W-1:0]        red,
    output logic [bbd_pkg::PIX_W-1:0]        green,
    output logic [bbd_pkg::PIX_W-1:0]        blue,
    output logic [bbd_pkg::COL_W-1:0]        pixel_column,
    output logic [bbd_pkg::ROW_W-1:0]        pixel_row,
    output logic                             quad_last
);
    import bbd_pkg::*;

    quad_t      quad_reg;
    logic       busy_reg;
    logic [1:0] phase_reg;
    logic       done;

    assign done = busy_reg && out_ready && (phase_reg == 2'd3);
    assign pop  = not_empty && (!busy_reg || done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= '0;
        end
        else if (pop)
        begin
            busy_reg  <= 1'b1;
            phase_reg <= '0;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg && out_ready)
        begin
            phase_reg <= phase_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            quad_reg <= head;
        end
    end

    assign out_valid    = busy_reg;
    assign red          = quad_reg.px[phase_reg].r;
    assign green        = quad_reg.px[phase_reg].g;
    assign blue         = quad_reg.px[phase_reg].b;
    assign pixel_column = quad_reg.x + COL_W'(phase_reg[0]);
    assign pixel_row    = quad_reg.y + ROW_W'(phase_reg[1]);
    assign quad_last    = (phase_reg == 2'd3);
endmodule
`default_nettype wire

// ===== src/bayer_bilinear_demosaic.sv =====
// Bilinear demosaic of an 8-bit GBRG Bayer stream into RGB pixels.
// Raw samples enter in raster order on the input channel (in_valid,
// in_ready, raw_pixel), one transaction per sample. RGB pixels leave on the
// output channel four at a time, one 2x2 quad in the order top-left,
// top-right, bottom-left, bottom-right, with quad_last on the fourth.
// The frame size is set on the configuration channel, which is always
// ready; it should only be written while the block is idle.
// A border quad leaves once its bottom-right sample is in; an interior quad
// once the sample two columns right and two rows down has arrived.
// A quad passes two pipeline stages behind the line store, the quad queue
// and the output register. The input takes one sample per cycle as long
// as the eight-quad queue has room; the output side delivers one pixel per
// cycle while the receiver is ready, so in even rows of the interior,
// which produce two pixels per sample, the queue fills and the input is
// throttled to the output rate. When the receiver stalls, the current
// pixel holds and the queue absorbs up to eight quads before the input
// channel drops ready. Reset clears the counters and the queue and sets
// the frame size to 640 x 480; the line store is not cleared and needs
// no clearing pass.
`default_nettype none
module bayer_bilinear_demosaic (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bbd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [bbd_pkg::PIX_W-1:0]      raw_pixel,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [bbd_pkg::PIX_W-1:0]           red,
    output logic [bbd_pkg::PIX_W-1:0]           green,
    output logic [bbd_pkg::PIX_W-1:0]           blue,
    output logic [bbd_pkg::COL_W-1:0]           pixel_column,
    output logic [bbd_pkg::ROW_W-1:0]           pixel_row,
    output logic                                quad_last
);
    import bbd_pkg::*;

    logic              accept;
    logic              push;
    quad_t             push_quad;
    logic [1:0]        pending;
    logic              pop;
    quad_t             head;
    logic              not_empty;
    logic [QCNT_W-1:0] count;

    assign cfg_ready = 1'b1;

    // Credit check: every quad already in flight in the front pipeline has a
    // reserved slot, so the pipeline itself never has to stall.
    assign in_ready = ({1'b0, count} + (QCNT_W + 1)'(pending)) < (QCNT_W + 1)'(QUEUE_DEPTH);
    assign accept   = in_valid && in_ready;

    bbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .raw_pixel (raw_pixel),
        .push      (push),
        .quad      (push_quad),
        .pending   (pending)
    );

    bbd_quad_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_quad (push_quad),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .count     (count)
    );

    bbd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .not_empty    (not_empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .quad_last    (quad_last)
    );
endmodule
`default_nettype wire

// ===== src/bbd_checker.sv =====
`default_nettype none
module bbd_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [bbd_pkg::COL_W-1:0]  pixel_column,
    input wire logic [bbd_pkg::ROW_W-1:0]  pixel_row,
    input wire logic                       quad_last
);
    // A stalled pixel stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped while stalled");

    // The last pixel of a quad is its bottom-right site.
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && quad_last |-> pixel_column[0] && pixel_row[0])
        else $error("quad_last on a pixel that is not bottom-right");

    // Pixels of one quad follow without a gap.
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !quad_last |=> out_valid)
        else $error("gap inside a quad");

    // The first pixel of a quad is its top-left site.
    a_first_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && quad_last |=> !out_valid
            || (!pixel_column[0] && !pixel_row[0]))
        else $error("quad does not start at its top-left site");
endmodule

bind bayer_bilinear_demosaic bbd_checker u_bbd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_column (pixel_column),
    .pixel_row    (pixel_row),
    .quad_last    (quad_last)
);
`default_nettype wire

// ===== bench/bayer_bilinear_demosaic_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module bayer_bilinear_demosaic_tb;
    import bbd_pkg::*;

    // A generous bound on the whole run, in clock cycles.
    localparam int CYCLE_LIMIT = 2000000;
    // Register index outside the list: the block must ignore the write.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    // Cycles allowed after the last pixel for the pipeline to settle.
    localparam int SETTLE = 8;
    localparam int DIR_ROWS = 24;

    typedef struct packed {
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } pixel_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [PIX_W-1:0]      raw_pixel;
    logic                  out_valid;
    logic                  out_ready;
    logic [PIX_W-1:0]      red;
    logic [PIX_W-1:0]      green;
    logic [PIX_W-1:0]      blue;
    logic [COL_W-1:0]      pixel_column;
    logic [ROW_W-1:0]      pixel_row;
    logic                  quad_last;

    bayer_bilinear_demosaic DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .raw_pixel    (raw_pixel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .quad_last    (quad_last)
    );

    // Shadow state of the demosaic: four lines of samples, the raster
    // position and the two size registers.
    logic [PIX_W-1:0] line_mem [LINES_KEPT][MAX_WIDTH];
    int               raster_col;
    int               raster_row;
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;

    pixel_t pixels_due [$];
    int     errors;
    int     cycles;
    int     samples_sent;
    int     pixels_seen;
    int     frames_done;
    int     send_idle_pct;
    int     recv_stall_pct;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Watchdog: a hung handshake must not stall the run forever.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch at pixel %0d: %s got %0d expected %0d",
                 pixels_seen, what, got, want);
        errors++;
    endtask

    // Effective frame size: the low bit is dropped and the value clamped.
    function automatic int eff_width();
        int w;
        w = width_reg & 12'hFFE;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (w < 2) w = 2;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = height_reg & 13'h1FFE;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        if (h < 2) h = 2;
        return h;
    endfunction

    function automatic int sample_at(input int col, input int row);
        return line_mem[row % LINES_KEPT][col % MAX_WIDTH];
    endfunction

    task automatic queue_pixel(input int r, input int g, input int b,
                               input int col, input int row, input bit last);
        pixel_t p;
        p.r    = r;
        p.g    = g;
        p.b    = b;
        p.col  = col;
        p.row  = row;
        p.last = last;
        pixels_due.push_back(p);
    endtask

    // Border quad: greens keep their own sample, the two non-green sites take
    // the mean of the greens, and the one red and one blue are replicated.
    task automatic copy_border_quad(input int x, input int y);
        int g0, g1, gm, rd, bl;
        g0 = sample_at(x, y);
        g1 = sample_at(x + 1, y + 1);
        gm = (g0 + g1) / 2;
        rd = sample_at(x, y + 1);
        bl = sample_at(x + 1, y);
        queue_pixel(rd, g0, bl, x, y, 1'b0);
        queue_pixel(rd, gm, bl, x + 1, y, 1'b0);
        queue_pixel(rd, gm, bl, x, y + 1, 1'b0);
        queue_pixel(rd, g1, bl, x + 1, y + 1, 1'b1);
    endtask

    // Interior quad: bilinear averages of the neighbouring sites, truncated.
    task automatic blend_interior_quad(input int x, input int y);
        int r, g, b;
        r = (sample_at(x, y + 1) + sample_at(x, y - 1)) / 2;
        g = sample_at(x, y);
        b = (sample_at(x - 1, y) + sample_at(x + 1, y)) / 2;
        queue_pixel(r, g, b, x, y, 1'b0);
        r = (sample_at(x, y + 1) + sample_at(x + 2, y + 1)
             + sample_at(x, y - 1) + sample_at(x + 2, y - 1)) / 4;
        g = (sample_at(x, y) + sample_at(x + 2, y)
             + sample_at(x + 1, y - 1) + sample_at(x + 1, y + 1)) / 4;
        b = sample_at(x + 1, y);
        queue_pixel(r, g, b, x + 1, y, 1'b0);
        r = sample_at(x, y + 1);
        g = (sample_at(x, y) + sample_at(x, y + 2)
             + sample_at(x - 1, y + 1) + sample_at(x + 1, y + 1)) / 4;
        b = (sample_at(x + 1, y) + sample_at(x - 1, y)
             + sample_at(x + 1, y + 2) + sample_at(x - 1, y + 2)) / 4;
        queue_pixel(r, g, b, x, y + 1, 1'b0);
        r = (sample_at(x, y + 1) + sample_at(x + 2, y + 1)) / 2;
        g = sample_at(x + 1, y + 1);
        b = (sample_at(x + 1, y) + sample_at(x + 1, y + 2)) / 2;
        queue_pixel(r, g, b, x + 1, y + 1, 1'b1);
    endtask

    // Takes one accepted sample into the shadow state and queues the pixels
    // it releases. With keep clear the state advances but nothing is queued,
    // for rows whose expected pixels are typed into the table.
    task automatic absorb_sample(input logic [PIX_W-1:0] p, input bit keep);
        int w, h, c, r, n;
        w = eff_width();
        h = eff_height();
        c = raster_col;
        r = raster_row;
        n = pixels_due.size();
        if (c < w && r < h)
        begin
            line_mem[r % LINES_KEPT][c % MAX_WIDTH] = p;
            if (c % 2 == 1 && r % 2 == 1)
            begin
                if (c - 1 == 0 || r - 1 == 0 || c - 1 == w - 2 || r - 1 == h - 2)
                    copy_border_quad(c - 1, r - 1);
            end
            else if (c % 2 == 0 && r % 2 == 0 && c >= 4 && r >= 4
                     && c <= w - 2 && r <= h - 2)
                blend_interior_quad(c - 2, r - 2);
        end
        if (!keep)
            while (pixels_due.size() > n)
                void'(pixels_due.pop_back());
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        raster_col = c & 'h7FF;
        raster_row = r & 'hFFF;
    endtask

    // Sender: an optional idle gap, then the sample is held until accepted.
    // Valid is only lowered at the start of a gap, so it is never dropped
    // and raised within one time step.
    task automatic send_sample(input logic [PIX_W-1:0] p, input bit keep);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        raw_pixel <= p;
        do
            @(posedge clk);
        while (!in_ready);
        samples_sent++;
        absorb_sample(p, keep);
    endtask

    // Waits until the block has delivered every pixel due, then lets the
    // pipeline drain before a register is touched.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pixels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
            width_reg = value[FW_W-1:0];
        else if (idx == REG_FRAME_HEIGHT)
            height_reg = value;
        @(posedge clk);
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] w,
                             input logic [CFG_DATA_W-1:0] h);
        wait_drained();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    // One whole frame of samples; style 1 uses only the extreme values.
    task automatic send_frame(input int style);
        int n;
        logic [PIX_W-1:0] p;
        n = eff_width() * eff_height();
        for (int i = 0; i < n; i++)
        begin
            p = $urandom_range(255);
            if (style == 1) p = $urandom_range(1) ? 8'hFF : 8'h00;
            send_sample(p, 1'b1);
        end
        frames_done++;
    endtask

    task automatic pick_phase(input int ph);
        case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
        endcase
    endtask

    // Receiver: each accepted pixel is checked against the oldest one due,
    // and ready is redrawn every cycle according to the current phase.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pixels_due.size() == 0)
                begin
                    $display("unexpected pixel at column %0d row %0d",
                             pixel_column, pixel_row);
                    errors++;
                end
                else
                begin
                    pixel_t want;
                    want = pixels_due.pop_front();
                    if (red !== want.r) report("red", red, want.r);
                    if (green !== want.g) report("green", green, want.g);
                    if (blue !== want.b) report("blue", blue, want.b);
                    if (pixel_column !== want.col)
                        report("column", pixel_column, want.col);
                    if (pixel_row !== want.row) report("row", pixel_row, want.row);
                    if (quad_last !== want.last)
                        report("quad_last", quad_last, want.last);
                end
                pixels_seen++;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Directed table. The first eight samples make two 2x2 frames, one all
    // full scale and one all zero, whose pixels are typed in by hand; the
    // remaining sixteen fill a 4x4 frame that is all border quads, with
    // mixed values, checked by the shadow model. A value of -1 in the
    // typed column means the row is checked by the model.
    logic [PIX_W-1:0] dir_pix [DIR_ROWS] = '{
        8'hFF, 8'hFF, 8'hFF, 8'hFF,  8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'hFF, 8'h01, 8'hFE,  8'hFF, 8'h00, 8'h80, 8'h7F,
        8'hAA, 8'h55, 8'hFF, 8'hFF,  8'h01, 8'h00, 8'hFF, 8'h03
    };
    int dir_typed [DIR_ROWS] = '{
        -1, -1, -1, 255,  -1, -1, -1, 0,
        -1, -1, -1, -1,   -1, -1, -1, -1,
        -1, -1, -1, -1,   -1, -1, -1, -1
    };

    initial
    begin
        int ph;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_FRAME_WIDTH;
        cfg_data       = '0;
        in_valid       = 1'b0;
        raw_pixel      = '0;
        out_ready      = 1'b0;
        errors         = 0;
        cycles         = 0;
        samples_sent   = 0;
        pixels_seen    = 0;
        frames_done    = 0;
        raster_col     = 0;
        raster_row     = 0;
        width_reg      = FRAME_WIDTH_RESET;
        height_reg     = FRAME_HEIGHT_RESET;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: smallest frame, with an ignored write to an unused
        // index between the two size writes.
        write_reg(REG_FRAME_WIDTH, 13'd2);
        write_reg(REG_UNUSED, 13'h1FFF);
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (i == 8)
                set_frame(13'd4, 13'd4);
            send_sample(dir_pix[i], dir_typed[i] < 0);
            if (dir_typed[i] >= 0)
            begin
                queue_pixel(dir_typed[i], dir_typed[i], dir_typed[i], 0, 0, 1'b0);
                queue_pixel(dir_typed[i], dir_typed[i], dir_typed[i], 1, 0, 1'b0);
                queue_pixel(dir_typed[i], dir_typed[i], dir_typed[i], 0, 1, 1'b0);
                queue_pixel(dir_typed[i], dir_typed[i], dir_typed[i], 1, 1, 1'b1);
            end
        end

        // Random part: mostly small frames with random content, odd sizes
        // and high unused bits included, under every idling phase.
        ph = 0;
        while (samples_sent < 370)
        begin
            pick_phase(ph);
            set_frame({$urandom_range(1), 8'd0, 4'($urandom_range(15))},
                      13'($urandom_range(14)));
            send_frame($urandom_range(7) == 0);
            ph++;
        end

        // Size extremes: a zero width that clamps up to the minimum, and an
        // odd width with a height of one that clamps up to two rows.
        pick_phase(1);
        set_frame(13'd0, 13'd10);
        send_frame(0);
        pick_phase(2);
        set_frame(13'd15, 13'd1);
        send_frame(1);

        wait_drained();
        $display("%0d samples in %0d frames, %0d RGB pixels checked",
                 samples_sent, frames_done, pixels_seen);
        $display("frames from 2x2 up to 14x14 with odd and clamped sizes, four idling phases");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
src/bbd_pkg.sv
src/bbd_ram.sv
src/bbd_front.sv
src/bbd_quad_fifo.sv
src/bbd_back.sv
src/bayer_bilinear_demosaic.sv
src/bbd_checker.sv
bench/bayer_bilinear_demosaic_tb.sv
